@@ sv/fisvr_pkg.sv @@
// Shared types and constants of the face index stream vertex remapper.
`timescale 1ns / 1ps

package fisvr_pkg;

    localparam int MAX_POINTS_DEF = 4096;

    localparam int IDX_W   = 32;
    localparam int OUT_VW  = 12;
    localparam int STAT_W  = 3;
    localparam int VTOT_W  = 13;
    localparam int FTOT_W  = 24;
    localparam int KIND_W  = 2;
    localparam int PCNT_W  = 13;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 13;
    localparam int OUT_DW  = 104;

    localparam logic [IDX_W-1:0]  END_MARK = 32'hFFFF_FFFF;
    localparam logic [FTOT_W-1:0] FACE_SAT = 24'hFF_FFFF;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FACE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_FEW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_TOO_MANY = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

    // input ops
    localparam logic OP_INDEX  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RANGE_CHECK = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_VW-1:0] source_point;
        logic [OUT_VW-1:0] vertex_number;
        logic [OUT_VW-1:0] corner_a;
        logic [OUT_VW-1:0] corner_b;
        logic [OUT_VW-1:0] corner_c;
        logic [STAT_W-1:0] status;
        logic [VTOT_W-1:0] vertex_total;
        logic [FTOT_W-1:0] face_total;
        logic              last_of_run;
    } result_t;

endpackage

@@ sv/face_index_stream_vertex_remapper_unit.sv @@
// Top level of the face index stream vertex remapper.
`timescale 1ns / 1ps

// Takes a stream of point indices on s_axis (tuser: op, tdata: point_index) and
// gives new-vertex, face, error and finish result items on m_axis (tuser: kind,
// tlast: last result of the input item). point_count is written on the cfg
// channel (index 0); index 1 (range check) is accepted and has no effect.
// A plain index item is taken also while a face is being resolved.
// A face-closing -1 goes through 3 remap-memory reads (one read port), an
// evaluate state and an emit state that visits each corner (a vertex item for
// each new one) and then gives the face result; the next -1 is taken only after
// that. Its results pass S_RD0, S_RD1, S_RD2, S_EVAL and S_EMIT and then the
// output register before they show on m_axis.
// Corner count and empty errors and finish give a single result that passes
// S_ERR or S_FIN and then the output register; a range error passes S_ERR.
// After reset and after every finish the remap memory is swept, one entry per
// cycle, all MAX_POINTS entries; no item is accepted then, cfg writes still are.
// The finish totals item is issued before the sweep starts.
// Results wait in one output register; while it is full and m_axis_tready is
// low the engine holds, and only plain index items are taken meanwhile.

module face_index_stream_vertex_remapper_unit #(
    parameter int MAX_POINTS = fisvr_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fisvr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [fisvr_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] point_index
    input  logic [0:0]                    s_axis_tuser,   // [0] op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [11:0] source_point, [23:12] vertex_number, [35:24] corner_a,
    // [47:36] corner_b, [59:48] corner_c, [62:60] status,
    // [75:63] vertex_total, [99:76] face_total, [103:100] zero
    output logic [fisvr_pkg::OUT_DW-1:0]  m_axis_tdata,
    output logic [fisvr_pkg::KIND_W-1:0]  m_axis_tuser,   // [1:0] kind
    output logic                          m_axis_tlast    // last_of_run
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NVW = $clog2(MAX_POINTS + 1);

    logic [AW-1:0]      rd_addr;
    logic [AW:0]        rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW:0]        wr_data;
    logic               slot_free;
    logic               emit_valid;
    fisvr_pkg::result_t emit_res;

    assign cfg_ready = 1'b1;

    fisvr_engine #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .NVW        (NVW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_op      (s_axis_tuser[0]),
        .in_index   (s_axis_tdata),
        .in_ready   (s_axis_tready),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .slot_free  (slot_free),
        .emit_valid (emit_valid),
        .emit_res   (emit_res)
    );

    fisvr_remap_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DW    (AW + 1)
    ) u_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fisvr_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit_valid    (emit_valid),
        .emit_res      (emit_res),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/fisvr_remap_mem.sv @@
// Remap memory: seen flag and vertex number per point, registered read.
`timescale 1ns / 1ps

module fisvr_remap_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/fisvr_out_reg.sv @@
// Output register stage: holds one result item for the master side.
`timescale 1ns / 1ps

module fisvr_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           emit_valid,
    input  fisvr_pkg::result_t             emit_res,
    output logic                           slot_free,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fisvr_pkg::OUT_DW-1:0]   m_axis_tdata,
    output logic [fisvr_pkg::KIND_W-1:0]   m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic               valid_reg;
    logic               valid_next;
    fisvr_pkg::result_t res_reg;
    logic               load;

    assign slot_free  = !valid_reg || m_axis_tready;
    assign load       = emit_valid && slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= emit_res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last_of_run;
    assign m_axis_tdata  = {4'b0000, res_reg.face_total, res_reg.vertex_total,
                            res_reg.status, res_reg.corner_c, res_reg.corner_b,
                            res_reg.corner_a, res_reg.vertex_number,
                            res_reg.source_point};

endmodule

@@ sv/fisvr_engine.sv @@
// Control engine: corner buffering, face lookup sequence, commit and clear sweep.
`timescale 1ns / 1ps

module fisvr_engine #(
    parameter int MAX_POINTS = 4096,
    parameter int AW         = 12,
    parameter int NVW        = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [fisvr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [fisvr_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                          in_valid,
    input  logic                          in_op,
    input  logic [fisvr_pkg::IDX_W-1:0]   in_index,
    output logic                          in_ready,
    output logic [AW-1:0]                 rd_addr,
    input  logic [AW:0]                   rd_data,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [AW:0]                   wr_data,
    input  logic                          slot_free,
    output logic                          emit_valid,
    output fisvr_pkg::result_t            emit_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_ERR   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;

    localparam logic [31:0]   MAXP32   = 32'(MAX_POINTS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_POINTS - 1);

    // control state
    logic [3:0]                     state_reg, state_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [2:0]                     ccount_reg, ccount_next;
    logic [fisvr_pkg::STAT_W-1:0]   err_reg, err_next;
    logic [NVW-1:0]                 nv_reg, nv_next;
    logic [fisvr_pkg::FTOT_W-1:0]   faces_reg, faces_next;
    logic [fisvr_pkg::PCNT_W-1:0]   pc_reg, pc_next;
    logic [1:0]                     e_reg, e_next;

    // payload
    logic [31:0]        c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [31:0]        p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic               k0_reg, k0_next, k1_reg, k1_next;
    logic [AW-1:0]      r0_reg, r0_next, r1_reg, r1_next;
    logic [2:0]         new_reg, new_next;
    logic [NVW-1:0]     v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    fisvr_pkg::result_t one_reg, one_next;

    logic               plain;
    logic               busy_face;
    logic               acc;
    logic [31:0]        lim;
    logic               k2;
    logic               ev_err;
    logic               ev_new0, ev_new1, ev_new2;
    logic               eq10, eq20, eq21;
    logic [NVW-1:0]     ev_v0, ev_v1, ev_v2;
    logic               cur_new;
    logic [31:0]        cur_p;
    logic [NVW-1:0]     cur_v;

    function automatic fisvr_pkg::result_t err_res(input logic [fisvr_pkg::STAT_W-1:0] code);
        fisvr_pkg::result_t r;
        r             = '0;
        r.kind        = fisvr_pkg::KIND_ERROR;
        r.status      = code;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic logic known(input logic [31:0] p, input logic seen);
        return (p < MAXP32) && seen;
    endfunction

    assign plain     = (in_op == fisvr_pkg::OP_INDEX) && (in_index != fisvr_pkg::END_MARK);
    assign busy_face = (state_reg == S_RD0) || (state_reg == S_RD1) || (state_reg == S_RD2)
                    || (state_reg == S_EVAL) || (state_reg == S_EMIT) || (state_reg == S_ERR);
    // plain indices only touch the corner buffer, so they pass while a face is at work
    assign in_ready  = (state_reg == S_IDLE) || (plain && busy_face);
    assign acc       = in_valid && in_ready;

    // evaluation of the three looked-up corners; third read data arrives in S_EVAL
    assign lim     = (32'(pc_reg) < MAXP32) ? 32'(pc_reg) : MAXP32;
    assign k2      = known(p2_reg, rd_data[AW]);
    assign ev_err  = (!k0_reg && (p0_reg >= lim)) || (!k1_reg && (p1_reg >= lim))
                  || (!k2 && (p2_reg >= lim));
    assign eq10    = (p1_reg == p0_reg);
    assign eq20    = (p2_reg == p0_reg);
    assign eq21    = (p2_reg == p1_reg);
    assign ev_new0 = !k0_reg;
    assign ev_new1 = !k1_reg && !eq10;
    assign ev_new2 = !k2 && !eq20 && !eq21;
    assign ev_v0   = k0_reg ? NVW'(r0_reg) : nv_reg;
    assign ev_v1   = k1_reg ? NVW'(r1_reg) : (eq10 ? ev_v0 : nv_reg + NVW'(ev_new0));
    assign ev_v2   = k2 ? NVW'(rd_data[AW-1:0]) :
                     eq20 ? ev_v0 :
                     eq21 ? ev_v1 : nv_reg + NVW'(ev_new0) + NVW'(ev_new1);

    always_comb
    begin
        case (e_reg)
            2'd0:
            begin
                cur_new = new_reg[0];
                cur_p   = p0_reg;
                cur_v   = v0_reg;
            end
            2'd1:
            begin
                cur_new = new_reg[1];
                cur_p   = p1_reg;
                cur_v   = v1_reg;
            end
            2'd2:
            begin
                cur_new = new_reg[2];
                cur_p   = p2_reg;
                cur_v   = v2_reg;
            end
            default:
            begin
                cur_new = 1'b0;
                cur_p   = p0_reg;
                cur_v   = v0_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ccount_next = ccount_reg;
        err_next    = err_reg;
        nv_next     = nv_reg;
        faces_next  = faces_reg;
        pc_next     = pc_reg;
        e_next      = e_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        new_next    = new_reg;
        v0_next     = v0_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        one_next    = one_reg;
        rd_addr     = p0_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = clr_reg;
        wr_data     = '0;
        emit_valid  = 1'b0;
        emit_res    = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                fisvr_pkg::CFG_POINT_COUNT: pc_next = cfg_data;
                // out-of-range indexes are flagged either way, so the bit is not kept
                fisvr_pkg::CFG_RANGE_CHECK: ;
                default: ;
            endcase
        end

        if (acc && (in_op == fisvr_pkg::OP_INDEX) && (err_reg == fisvr_pkg::ST_OK))
        begin
            if (pc_reg == '0)
            begin
                err_next   = fisvr_pkg::ST_EMPTY;
                one_next   = err_res(fisvr_pkg::ST_EMPTY);
                state_next = S_ERR;
            end
            else if (plain)
            begin
                case (ccount_reg)
                    3'd0: c0_next = in_index;
                    3'd1: c1_next = in_index;
                    3'd2: c2_next = in_index;
                    default: ;
                endcase
                if (ccount_reg < 3'd4)
                begin
                    ccount_next = ccount_reg + 3'd1;
                end
            end
            else
            begin
                ccount_next = '0;
                if (ccount_reg < 3'd3)
                begin
                    err_next   = fisvr_pkg::ST_TOO_FEW;
                    one_next   = err_res(fisvr_pkg::ST_TOO_FEW);
                    state_next = S_ERR;
                end
                else if (ccount_reg > 3'd3)
                begin
                    err_next   = fisvr_pkg::ST_TOO_MANY;
                    one_next   = err_res(fisvr_pkg::ST_TOO_MANY);
                    state_next = S_ERR;
                end
                else
                begin
                    p0_next    = c0_reg;
                    p1_next    = c1_reg;
                    p2_next    = c2_reg;
                    state_next = S_RD0;
                end
            end
        end

        if (acc && (in_op == fisvr_pkg::OP_FINISH))
        begin
            one_next              = '0;
            one_next.kind         = fisvr_pkg::KIND_FINISH;
            one_next.status       = err_reg;
            one_next.vertex_total = fisvr_pkg::VTOT_W'(nv_reg);
            one_next.face_total   = faces_reg;
            one_next.last_of_run  = 1'b1;
            err_next              = fisvr_pkg::ST_OK;
            nv_next               = '0;
            faces_next            = '0;
            ccount_next           = '0;
            state_next            = S_FIN;
        end

        case (state_reg)
            S_IDLE: ;
            S_RD0:
            begin
                rd_addr    = p0_reg[AW-1:0];
                state_next = S_RD1;
            end
            S_RD1:
            begin
                rd_addr    = p1_reg[AW-1:0];
                k0_next    = known(p0_reg, rd_data[AW]);
                r0_next    = rd_data[AW-1:0];
                state_next = S_RD2;
            end
            S_RD2:
            begin
                rd_addr    = p2_reg[AW-1:0];
                k1_next    = known(p1_reg, rd_data[AW]);
                r1_next    = rd_data[AW-1:0];
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (ev_err)
                begin
                    err_next   = fisvr_pkg::ST_RANGE;
                    one_next   = err_res(fisvr_pkg::ST_RANGE);
                    state_next = S_ERR;
                end
                else
                begin
                    new_next = {ev_new2, ev_new1, ev_new0};
                    v0_next  = ev_v0;
                    v1_next  = ev_v1;
                    v2_next  = ev_v2;
                    nv_next  = nv_reg + NVW'(ev_new0) + NVW'(ev_new1) + NVW'(ev_new2);
                    if (faces_reg != fisvr_pkg::FACE_SAT)
                    begin
                        faces_next = faces_reg + 1'b1;
                    end
                    e_next     = 2'd0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (e_reg != 2'd3)
                begin
                    if (!cur_new)
                    begin
                        e_next = e_reg + 2'd1;
                    end
                    else if (slot_free)
                    begin
                        emit_valid             = 1'b1;
                        emit_res.kind          = fisvr_pkg::KIND_VERTEX;
                        emit_res.source_point  = cur_p[fisvr_pkg::OUT_VW-1:0];
                        emit_res.vertex_number = fisvr_pkg::OUT_VW'(cur_v);
                        wr_en                  = 1'b1;
                        wr_addr                = cur_p[AW-1:0];
                        wr_data                = {1'b1, cur_v[AW-1:0]};
                        e_next                 = e_reg + 2'd1;
                    end
                end
                else if (slot_free)
                begin
                    emit_valid           = 1'b1;
                    emit_res.kind        = fisvr_pkg::KIND_FACE;
                    emit_res.corner_a    = fisvr_pkg::OUT_VW'(v0_reg);
                    emit_res.corner_b    = fisvr_pkg::OUT_VW'(v1_reg);
                    emit_res.corner_c    = fisvr_pkg::OUT_VW'(v2_reg);
                    emit_res.last_of_run = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    emit_valid = 1'b1;
                    emit_res   = one_reg;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    emit_valid = 1'b1;
                    emit_res   = one_reg;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ccount_reg <= '0;
            err_reg    <= fisvr_pkg::ST_OK;
            nv_reg     <= '0;
            faces_reg  <= '0;
            pc_reg     <= '0;
            e_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ccount_reg <= ccount_next;
            err_reg    <= err_next;
            nv_reg     <= nv_next;
            faces_reg  <= faces_next;
            pc_reg     <= pc_next;
            e_reg      <= e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        k0_reg  <= k0_next;
        k1_reg  <= k1_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        new_reg <= new_next;
        v0_reg  <= v0_next;
        v1_reg  <= v1_next;
        v2_reg  <= v2_next;
        one_reg <= one_next;
    end

endmodule

@@ sv/fisvr_checker.sv @@
// Port-level checker of the remapper, bound to the top level.
`timescale 1ns / 1ps

module fisvr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fisvr_pkg::OUT_DW-1:0]  m_axis_tdata,
    input logic [fisvr_pkg::KIND_W-1:0]  m_axis_tuser,
    input logic                          m_axis_tlast
);

    // a stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // a new vertex item is never marked last, since its face follows
    a_vertex_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fisvr_pkg::KIND_VERTEX) |-> !m_axis_tlast)
        else $error("vertex item marked last");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == fisvr_pkg::KIND_FACE)
            || (m_axis_tuser == fisvr_pkg::KIND_FINISH)) |-> m_axis_tlast)
        else $error("face or finish item not marked last");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fisvr_pkg::KIND_ERROR)
            |-> m_axis_tlast && (m_axis_tdata[62:60] != fisvr_pkg::ST_OK))
        else $error("error item without code or not last");

endmodule

bind face_index_stream_vertex_remapper_unit fisvr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
